[src/zrv_pkg.sv]
// Shared types and constants for the zero-run visibility decoder.
`default_nettype none

package zrv_pkg;

	// Bytes in one packed output word
	localparam int unsigned WORD_BYTES = 8;

	// Sequencer states, one-hot
	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_DECODE = 3'b010,
		ST_RUN    = 3'b100
	} seq_state_t;

	// Result of one packing step
	typedef struct packed {
		logic [3:0] take;  // bytes added this step
		logic [3:0] fill;  // bytes in the word after the step
		logic       emit;  // word leaves this step
		logic       done;  // row is complete after the step
	} pack_res_t;

endpackage

`default_nettype wire

[src/zrv_pack_unit.sv]
// Shared packing unit: adds up to one word's worth of bytes to the assembly word.
`default_nettype none

module zrv_pack_unit #(
	parameter int ROW_W = 11
) (
	input  wire logic [63:0]      word,
	input  wire logic [2:0]       fill_cur,
	input  wire logic [ROW_W-1:0] row_cnt,
	input  wire logic [ROW_W-1:0] row_len,
	input  wire logic [7:0]       byte_cnt,
	input  wire logic [7:0]       byte_val,
	output zrv_pkg::pack_res_t    res,
	output logic [63:0]           word_next,
	output logic [ROW_W-1:0]      row_cnt_next
);

	localparam int SW = (ROW_W > 4) ? ROW_W : 4;

	logic [3:0]  space;
	logic [3:0]  take;
	logic [3:0]  fill;
	logic [SW-1:0] row_sum;

	// Take as many bytes as the word has room for, at most byte_cnt
	always_comb begin
		space = 4'(zrv_pkg::WORD_BYTES) - {1'b0, fill_cur};
		if (byte_cnt < {4'b0000, space}) begin
			take = byte_cnt[3:0];
		end else begin
			take = space;
		end
		fill = {1'b0, fill_cur} + take;
		row_sum = SW'(row_cnt) + SW'(take);
		row_cnt_next = row_sum[ROW_W-1:0];
		word_next = word | (64'(byte_val) << {fill_cur, 3'b000});
		res.take = take;
		res.fill = fill;
		res.done = (row_sum[ROW_W-1:0] >= row_len);
		res.emit = fill[3] | res.done;
	end

endmodule

`default_nettype wire

[src/zero_run_visibility_decoder_top.sv]
// Zero-run visibility row decoder: byte sequencer, packing unit and output register.
//
//  channel | signals                                           | dir
//  --------+---------------------------------------------------+-----
//  in      | in_valid, in_stall, vis_byte, row_start           | in
//  out     | out_valid, out_stall, pvs_word, valid_bytes,      | out
//          | row_done, run_clipped                             |
//  cfg     | cfg_we, cfg_wdata (num_leaves)                    | in
//
// A literal, a zero marker or a byte past the row end passes through accept, then decode.
// A run count passes through accept, decode and then the packing steps of the run; each step of the
// shared packing unit fills the assembly word up to its end or the row end, so a
// 255-byte run needs at most 33 steps. A stalled output register holds a step.
// Reset opens a row with num_leaves = 8192; no item is taken while a step is in flight.
`default_nettype none

module zero_run_visibility_decoder_top #(
	parameter int MAX_LEAVES = 8192
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  vis_byte,
	input  wire logic        row_start,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [63:0]      pvs_word,
	output logic [3:0]       valid_bytes,
	output logic             row_done,
	output logic             run_clipped,
	input  wire logic        cfg_we,
	input  wire logic [13:0] cfg_wdata
);

	localparam int MAX_ROW = (MAX_LEAVES + 7) / 8;
	localparam int RW      = $clog2(MAX_ROW + 1);
	localparam int LW      = $clog2(MAX_LEAVES + 1);
	localparam int CW      = (LW > 14) ? LW : 14;
	localparam int EW      = (RW > 8) ? RW : 8;

	zrv_pkg::seq_state_t state_q;

	logic [13:0]   num_leaves_q;
	logic          expect_q;
	logic [63:0]   word_q;
	logic [2:0]    fill_q;
	logic [RW-1:0] row_cnt_q;
	logic          finished_q;
	logic [7:0]    byte_q;
	logic [7:0]    run_left_q;
	logic          clip_q;
	logic          out_valid_q;

	logic [CW-1:0] leaves_c;
	logic [CW:0]   leaves_sum;
	logic [RW-1:0] row_len;
	logic [RW-1:0] row_rem;
	logic [EW-1:0] rem_e;
	logic [EW-1:0] byte_e;

	logic                 in_run;
	logic [7:0]           pack_cnt;
	logic [7:0]           pack_byte;
	zrv_pkg::pack_res_t   pack_res;
	logic [63:0]          pack_word;
	logic [RW-1:0]        pack_row_cnt;

	logic accept;
	logic out_free;
	logic row_full;
	logic is_literal;
	logic do_commit;
	logic do_flush;
	logic out_load;

	// Clamp the leaf count and derive the row length in bytes
	always_comb begin
		leaves_c = CW'(num_leaves_q);
		if (leaves_c == '0) begin
			leaves_c = CW'(1);
		end else if (leaves_c > CW'(MAX_LEAVES)) begin
			leaves_c = CW'(MAX_LEAVES);
		end
		leaves_sum = {1'b0, leaves_c} + (CW + 1)'(7);
		row_len = RW'(leaves_sum >> 3);
		row_rem = row_len - row_cnt_q;
		rem_e = EW'(row_rem);
		byte_e = EW'(byte_q);
	end

	// Feed the packing unit: one literal byte, or a chunk of run zeros
	assign in_run    = (state_q == zrv_pkg::ST_RUN);
	assign pack_cnt  = in_run ? run_left_q : 8'd1;
	assign pack_byte = in_run ? 8'd0 : byte_q;

	zrv_pack_unit #(
		.ROW_W (RW)
	) u_pack (
		.word         (word_q),
		.fill_cur     (fill_q),
		.row_cnt      (row_cnt_q),
		.row_len      (row_len),
		.byte_cnt     (pack_cnt),
		.byte_val     (pack_byte),
		.res          (pack_res),
		.word_next    (pack_word),
		.row_cnt_next (pack_row_cnt)
	);

	// Step control
	always_comb begin
		accept     = (state_q == zrv_pkg::ST_IDLE) && in_valid;
		out_free   = !out_valid_q || !out_stall;
		row_full   = (row_cnt_q >= row_len);
		is_literal = !finished_q && !row_full && !expect_q && (byte_q != 8'd0);
		do_flush   = (state_q == zrv_pkg::ST_DECODE) && !finished_q && row_full
			&& (fill_q != 3'd0) && out_free;
		do_commit  = (((state_q == zrv_pkg::ST_DECODE) && is_literal)
			|| (in_run && (run_left_q != 8'd0)))
			&& (!pack_res.emit || out_free);
		out_load   = do_flush || (do_commit && pack_res.emit);
	end

	assign in_stall = (state_q != zrv_pkg::ST_IDLE);

	// Sequencer and row state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= zrv_pkg::ST_IDLE;
			num_leaves_q <= 14'd8192;
			expect_q     <= 1'b0;
			word_q       <= '0;
			fill_q       <= '0;
			row_cnt_q    <= '0;
			finished_q   <= 1'b0;
			byte_q       <= '0;
			run_left_q   <= '0;
			clip_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				num_leaves_q <= cfg_wdata;
			end
			// Advance the assembly word on a packing step
			if (do_commit) begin
				row_cnt_q <= pack_row_cnt;
				if (pack_res.emit) begin
					word_q     <= '0;
					fill_q     <= '0;
					finished_q <= pack_res.done;
				end else begin
					word_q <= pack_word;
					fill_q <= pack_res.fill[2:0];
				end
			end
			case (state_q)
				zrv_pkg::ST_IDLE: begin
					if (accept) begin
						byte_q <= vis_byte;
						if (row_start) begin
							expect_q   <= 1'b0;
							word_q     <= '0;
							fill_q     <= '0;
							row_cnt_q  <= '0;
							finished_q <= 1'b0;
						end
						state_q <= zrv_pkg::ST_DECODE;
					end
				end
				zrv_pkg::ST_DECODE: begin
					if (finished_q) begin
						state_q <= zrv_pkg::ST_IDLE;
					end else if (row_full) begin
						// Close a row that a shorter length has overrun
						expect_q <= 1'b0;
						if (fill_q == 3'd0) begin
							finished_q <= 1'b1;
							state_q    <= zrv_pkg::ST_IDLE;
						end else if (do_flush) begin
							word_q     <= '0;
							fill_q     <= '0;
							finished_q <= 1'b1;
							state_q    <= zrv_pkg::ST_IDLE;
						end
					end else if (expect_q) begin
						// Start a run, cut at the row end
						expect_q <= 1'b0;
						if (byte_e > rem_e) begin
							run_left_q <= rem_e[7:0];
							clip_q     <= 1'b1;
						end else begin
							run_left_q <= byte_q;
							clip_q     <= 1'b0;
						end
						state_q <= zrv_pkg::ST_RUN;
					end else if (byte_q == 8'd0) begin
						expect_q <= 1'b1;
						state_q  <= zrv_pkg::ST_IDLE;
					end else if (do_commit) begin
						state_q <= zrv_pkg::ST_IDLE;
					end
				end
				zrv_pkg::ST_RUN: begin
					if (run_left_q == 8'd0) begin
						state_q <= zrv_pkg::ST_IDLE;
					end else if (do_commit) begin
						run_left_q <= run_left_q - {4'b0000, pack_res.take};
					end
				end
				default: begin
					state_q <= zrv_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Hold the output request until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			if (do_flush) begin
				pvs_word    <= word_q;
				valid_bytes <= {1'b0, fill_q};
				row_done    <= 1'b1;
				run_clipped <= 1'b0;
			end else begin
				pvs_word    <= pack_word;
				valid_bytes <= pack_res.fill;
				row_done    <= pack_res.done;
				run_clipped <= in_run && clip_q && pack_res.done;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

[dv/zero_run_visibility_decoder_top_test.sv]
// Testbench for the zero-run visibility decoder: directed table, then random rows vs. predictor.

module zero_run_visibility_decoder_top_test;

	localparam int MAX_LEAVES = 8192;
	localparam int RAND_ITEMS = 260;
	localparam int DRAIN_CYCLES = 40;
	localparam int HOLD_AFTER = 60;
	localparam int HOLD_CYCLES = 400;
	localparam int CYCLE_LIMIT = 800000;

	// One decoded word as it leaves the block
	typedef struct packed {
		logic [63:0] word;
		logic [3:0]  nbytes;
		logic        last;
		logic        clip;
	} pvs_res_t;

	// How a directed row is handled
	typedef enum logic [1:0] {
		RK_PREDICT,  // request, results from the predictor
		RK_QUIET,    // request that yields no word
		RK_TYPED,    // request that yields the one word typed in the row
		RK_SETUP     // write num_leaves
	} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [13:0] leaves;
		logic [7:0]  b;
		logic        s;
		logic [63:0] word;
		logic [3:0]  nbytes;
		logic        last;
		logic        clip;
	} dir_row_t;

	localparam int NDIR = 29;
	localparam dir_row_t DIR_TAB [NDIR] = '{
		// open row right after reset, default row length of 1024 bytes
		'{RK_QUIET,   14'd0,     8'hFF, 1'b1, 64'h0,      4'd0, 1'b0, 1'b0},
		'{RK_QUIET,   14'd0,     8'h01, 1'b0, 64'h0,      4'd0, 1'b0, 1'b0},
		// empty run, then the longest run
		'{RK_QUIET,   14'd0,     8'h00, 1'b0, 64'h0,      4'd0, 1'b0, 1'b0},
		'{RK_QUIET,   14'd0,     8'h00, 1'b0, 64'h0,      4'd0, 1'b0, 1'b0},
		'{RK_QUIET,   14'd0,     8'h00, 1'b0, 64'h0,      4'd0, 1'b0, 1'b0},
		'{RK_PREDICT, 14'd0,     8'hFF, 1'b0, 64'h0,      4'd0, 1'b0, 1'b0},
		// shrink the row under a partial word, then bytes past the end
		'{RK_SETUP,   14'd0,     8'h00, 1'b0, 64'h0,      4'd0, 1'b0, 1'b0},
		'{RK_TYPED,   14'd0,     8'h80, 1'b0, 64'h0,      4'd1, 1'b1, 1'b0},
		'{RK_QUIET,   14'd0,     8'h7F, 1'b0, 64'h0,      4'd0, 1'b0, 1'b0},
		// one-byte rows: literal, then a clipped run
		'{RK_TYPED,   14'd0,     8'hAB, 1'b1, 64'hAB,     4'd1, 1'b1, 1'b0},
		'{RK_QUIET,   14'd0,     8'h00, 1'b1, 64'h0,      4'd0, 1'b0, 1'b0},
		'{RK_TYPED,   14'd0,     8'h05, 1'b0, 64'h0,      4'd1, 1'b1, 1'b1},
		// two-byte rows: literals, then a run that fits exactly
		'{RK_SETUP,   14'd9,     8'h00, 1'b0, 64'h0,      4'd0, 1'b0, 1'b0},
		'{RK_QUIET,   14'd0,     8'h01, 1'b1, 64'h0,      4'd0, 1'b0, 1'b0},
		'{RK_TYPED,   14'd0,     8'hFF, 1'b0, 64'hFF01,   4'd2, 1'b1, 1'b0},
		'{RK_QUIET,   14'd0,     8'h00, 1'b1, 64'h0,      4'd0, 1'b0, 1'b0},
		'{RK_TYPED,   14'd0,     8'h02, 1'b0, 64'h0,      4'd2, 1'b1, 1'b0},
		// leaf count above the maximum, long run leaves seven bytes pending
		'{RK_SETUP,   14'd16383, 8'h00, 1'b0, 64'h0,      4'd0, 1'b0, 1'b0},
		'{RK_QUIET,   14'd0,     8'h00, 1'b1, 64'h0,      4'd0, 1'b0, 1'b0},
		'{RK_PREDICT, 14'd0,     8'hFF, 1'b0, 64'h0,      4'd0, 1'b0, 1'b0},
		'{RK_SETUP,   14'd8,     8'h00, 1'b0, 64'h0,      4'd0, 1'b0, 1'b0},
		'{RK_TYPED,   14'd0,     8'h10, 1'b0, 64'h0,      4'd7, 1'b1, 1'b0},
		'{RK_QUIET,   14'd0,     8'h20, 1'b0, 64'h0,      4'd0, 1'b0, 1'b0},
		// shrink on a word boundary: row closes with no word
		'{RK_SETUP,   14'd8192,  8'h00, 1'b0, 64'h0,      4'd0, 1'b0, 1'b0},
		'{RK_QUIET,   14'd0,     8'h00, 1'b1, 64'h0,      4'd0, 1'b0, 1'b0},
		'{RK_TYPED,   14'd0,     8'h08, 1'b0, 64'h0,      4'd8, 1'b0, 1'b0},
		'{RK_SETUP,   14'd1,     8'h00, 1'b0, 64'h0,      4'd0, 1'b0, 1'b0},
		'{RK_QUIET,   14'd0,     8'h33, 1'b0, 64'h0,      4'd0, 1'b0, 1'b0},
		'{RK_QUIET,   14'd0,     8'h44, 1'b0, 64'h0,      4'd0, 1'b0, 1'b0}
	};

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  vis_byte;
	logic        row_start;
	logic        out_valid;
	logic        out_stall;
	logic [63:0] pvs_word;
	logic [3:0]  valid_bytes;
	logic        row_done;
	logic        run_clipped;
	logic        cfg_we;
	logic [13:0] cfg_wdata;

	// Predictor state
	logic [13:0] p_leaves;
	bit          p_marker;
	logic [63:0] p_word;
	int unsigned p_fill;
	int unsigned p_row_bytes;
	bit          p_row_done;

	pvs_res_t    pending_words [$];
	pvs_res_t    step_words [$];

	int          errors = 0;
	int          cycle_cnt = 0;
	int          words_seen = 0;
	int          items_done = 0;
	int unsigned rx_wait = 0;
	bit          rx_fast = 0;
	bit          tx_fast = 0;

	zero_run_visibility_decoder_top #(
		.MAX_LEAVES(MAX_LEAVES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.vis_byte(vis_byte),
		.row_start(row_start),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pvs_word(pvs_word),
		.valid_bytes(valid_bytes),
		.row_done(row_done),
		.run_clipped(run_clipped),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		errors++;
		$display("MISMATCH cycle %0d: %s got %0h expected %0h", cycle_cnt, what, got, want);
	endtask

	function automatic int unsigned row_len();
		int unsigned n;
		n = p_leaves;
		if (n < 1)
			n = 1;
		if (n > MAX_LEAVES)
			n = MAX_LEAVES;
		return (n + 7) >> 3;
	endfunction

	// Send out the assembled word and clear it
	task automatic emit_word(input bit last, input bit clip);
		step_words.push_back('{p_word, 4'(p_fill), last, clip});
		p_word = '0;
		p_fill = 0;
		if (last)
			p_row_done = 1;
	endtask

	task automatic add_byte(input logic [7:0] b, input int unsigned rlen, input bit clip);
		bit last;
		p_word[p_fill * 8 +: 8] = b;
		p_fill++;
		p_row_bytes++;
		last = (p_row_bytes >= rlen);
		if (p_fill >= 8 || last)
			emit_word(last, last && clip);
	endtask

	// Work out the words that one request yields
	task automatic decode_request(input logic [7:0] b, input logic s, output bit skipped);
		int unsigned rlen;
		int unsigned n;
		bit clipped;
		rlen = row_len();
		step_words.delete();
		skipped = 0;
		if (s) begin
			p_marker = 0;
			p_word = '0;
			p_fill = 0;
			p_row_bytes = 0;
			p_row_done = 0;
		end
		if (p_row_done) begin
			skipped = 1;
			return;
		end
		if (p_row_bytes >= rlen) begin
			// row shrunk under us: close it
			p_marker = 0;
			if (p_fill > 0)
				emit_word(1, 0);
			else
				p_row_done = 1;
		end else if (p_marker) begin
			p_marker = 0;
			n = b;
			clipped = 0;
			if (n > rlen - p_row_bytes) begin
				n = rlen - p_row_bytes;
				clipped = 1;
			end
			repeat (n) add_byte(8'h00, rlen, clipped);
		end else if (b == 8'h00) begin
			p_marker = 1;
		end else begin
			add_byte(b, rlen, 0);
		end
	endtask

	// Offer one request and wait for it to be taken
	task automatic send_request(input logic [7:0] b, input logic s, input bit use_model);
		int unsigned gap;
		bit skipped;
		gap = tx_fast ? 0 : $urandom_range(0, 9);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		vis_byte <= b;
		row_start <= s;
		do @(posedge clk); while (in_stall);
		decode_request(b, s, skipped);
		if (use_model)
			foreach (step_words[k]) pending_words.push_back(step_words[k]);
		if (!skipped)
			items_done++;
	endtask

	// Drain the block, then write num_leaves
	task automatic set_leaves(input logic [13:0] v);
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_words.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		p_leaves = v;
	endtask

	// Feed one row, whole or cut short, with random content
	task automatic feed_row(input bit whole);
		int unsigned stop_after;
		int unsigned sent;
		int unsigned left;
		int unsigned cnt;
		stop_after = whole ? 100000 : $urandom_range(1, 6);
		send_request(8'($urandom_range(0, 255)), 1'b1, 1);
		sent = 1;
		while (!p_row_done && sent < stop_after) begin
			left = row_len() - p_row_bytes;
			if (p_marker) begin
				case ($urandom_range(0, 3))
					0: cnt = $urandom_range(0, 255);
					1: cnt = (left > 255) ? 255 : left;
					default: begin
						if (left > 64)
							cnt = $urandom_range(128, 255);
						else
							cnt = $urandom_range(0, left + 1);
					end
				endcase
				send_request(8'(cnt), 1'b0, 1);
			end else if (left > 64 ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 2) == 0)) begin
				send_request(8'h00, 1'b0, 1);
			end else begin
				send_request(8'($urandom_range(1, 255)), 1'b0, 1);
			end
			sent++;
		end
		// trailing bytes past the row end
		if (p_row_done && $urandom_range(0, 3) == 0)
			send_request(8'($urandom_range(0, 255)), 1'b0, 1);
	endtask

	function automatic logic [13:0] pick_leaves();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 4))
					0: return 14'd0;
					1: return 14'd16383;
					2: return 14'd8192;
					3: return 14'd8193;
					default: return 14'd8191;
				endcase
			end
			1: return 14'($urandom_range(257, 16383));
			default: return 14'($urandom_range(1, 128));
		endcase
	endfunction

	// Receiver: random stall before each word, one long hold-off
	initial begin
		int unsigned hold_left;
		bit held;
		hold_left = 0;
		held = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			// start the hold-off while a request waits at the input
			if (!held && words_seen >= HOLD_AFTER && in_valid && in_stall) begin
				held = 1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (rx_wait != 0) begin
				rx_wait--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Check each accepted word against the oldest expectation
	always @(posedge clk) begin
		pvs_res_t want;
		if (arst_n && out_valid && !out_stall) begin
			words_seen++;
			if (words_seen % 40 == 0)
				rx_fast = ($urandom_range(0, 2) == 0);
			rx_wait = rx_fast ? 0 : $urandom_range(0, 9);
			if (pending_words.size() == 0) begin
				report_mismatch("word with none pending", pvs_word, 64'h0);
			end else begin
				want = pending_words.pop_front();
				if (pvs_word !== want.word)
					report_mismatch("pvs_word", pvs_word, want.word);
				if (valid_bytes !== want.nbytes)
					report_mismatch("valid_bytes", 64'(valid_bytes), 64'(want.nbytes));
				if (row_done !== want.last)
					report_mismatch("row_done", 64'(row_done), 64'(want.last));
				if (run_clipped !== want.clip)
					report_mismatch("run_clipped", 64'(run_clipped), 64'(want.clip));
			end
		end
	end

	// Stimulus
	initial begin
		dir_row_t r;
		int k;
		arst_n = 1'b0;
		in_valid = 1'b0;
		vis_byte = 8'h00;
		row_start = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 14'd0;
		p_leaves = 14'd8192;
		p_marker = 0;
		p_word = '0;
		p_fill = 0;
		p_row_bytes = 0;
		p_row_done = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// walk the directed table
		for (int i = 0; i < NDIR; i++) begin
			r = DIR_TAB[i];
			if (r.kind == RK_SETUP) begin
				set_leaves(r.leaves);
			end else begin
				send_request(r.b, r.s, r.kind == RK_PREDICT);
				if (r.kind == RK_TYPED)
					pending_words.push_back('{r.word, r.nbytes, r.last, r.clip});
			end
		end

		// random phases: new row length, then a few rows and some noise
		items_done = 0;
		while (items_done < RAND_ITEMS) begin
			set_leaves(pick_leaves());
			tx_fast = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(2, 4)) begin
				k = $urandom_range(0, 7);
				if (k == 0)
					send_request(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0, 1);
				else
					feed_row(k != 1);
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

[sim.f]
src/zrv_pkg.sv
src/zrv_pack_unit.sv
src/zero_run_visibility_decoder_top.sv
dv/zero_run_visibility_decoder_top_test.sv
